/* sv/fri_pkg.sv */
// ----------------------------------------------------------------------------
// FASTA record indexer package
// Shared constants, byte codes, operation and line-kind types for the
// record indexer front end, queue and back end.
// ----------------------------------------------------------------------------
package fri_pkg;

   // Width of the internal offset and length counters. They wrap at this width.
   localparam int COUNT_WIDTH = 32;

   // Width of every numeric result field.
   localparam int OUT_WIDTH = 32;

   // Decoupling queue between front and back end.
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Input action codes.
   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_END  = 1'b1;

   // Byte values that steer line classification.
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_GT      = 8'h3E;
   localparam logic [7:0] CHAR_AT      = 8'h40;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   // Operation handed from the front end to the back end.
   typedef enum logic [2:0] {
      OP_SEQ_BYTE,
      OP_SKIP_BYTE,
      OP_HEAD_BYTE,
      OP_NEWLINE,
      OP_END
   } op_type;

   // Class of the line being scanned.
   typedef enum logic [1:0] {
      KIND_SEQ,
      KIND_SKIP,
      KIND_HEAD
   } kind_type;

   // One queue entry.
   typedef struct packed {
      op_type op;
   } item_type;

endpackage

/* sv/fri_if.sv */
// ----------------------------------------------------------------------------
// FASTA record indexer channels
// Valid/ready channels for the byte stream and for the index records.
// ----------------------------------------------------------------------------
interface fri_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] byte_value;

   modport source (output valid, output action, output byte_value, input ready);
   modport sink (input valid, input action, input byte_value, output ready);
endinterface

interface fri_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] record_number;
   logic [31:0] header_start;
   logic [31:0] sequence_offset;
   logic [31:0] sequence_length;
   logic [31:0] widest_line;
   logic        final_record;

   modport source (
      output valid, output record_number, output header_start,
      output sequence_offset, output sequence_length, output widest_line,
      output final_record, input ready
   );
   modport sink (
      input valid, input record_number, input header_start,
      input sequence_offset, input sequence_length, input widest_line,
      input final_record, output ready
   );
endinterface

/* sv/fasta_record_indexer.sv */
// A record passes through the queue and the output register before it is valid on the result channel.
// The block takes one byte or end marker per cycle while the queue has room.
// A two-entry queue between classifier and back end absorbs result back-pressure.
// Reset is synchronous and active high; it empties the queue and output register
// and clears all line and record state, so the next beat starts a new file.
// ----------------------------------------------------------------------------
// FASTA record indexer
// Builds index records (header offset, sequence offset, length and widest
// line) from a FASTA/FASTQ byte stream.
// ----------------------------------------------------------------------------
module fasta_record_indexer (
   input  logic        clock,
   input  logic        reset,
   fri_req_if.sink     req_bus,
   fri_rsp_if.source   rsp_bus
);

   logic              push_valid;
   logic              push_ready;
   fri_pkg::item_type push_item;
   logic              pop_valid;
   logic              pop_ready;
   fri_pkg::item_type pop_item;

   // Byte classification.
   fri_front u_front (
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // Decoupling queue.
   fri_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   // Record builder and output register.
   fri_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

/* sv/fri_front.sv */
// ----------------------------------------------------------------------------
// FASTA record indexer front end
// Accepts input beats and classifies each byte into a back-end operation.
// ----------------------------------------------------------------------------
module fri_front (
   fri_req_if.sink               req_bus,
   output logic                  push_valid,
   output fri_pkg::item_type     push_item,
   input  logic                  push_ready
);

   // A beat is taken whenever the queue has room.
   assign req_bus.ready = push_ready;
   assign push_valid    = req_bus.valid;

   // Classify the byte. The class only matters when it opens a line.
   always_comb begin
      push_item.op = fri_pkg::OP_SEQ_BYTE;
      if (req_bus.action == fri_pkg::ACTION_END) begin
         push_item.op = fri_pkg::OP_END;
      end else if (req_bus.byte_value == fri_pkg::CHAR_NEWLINE) begin
         push_item.op = fri_pkg::OP_NEWLINE;
      end else if (req_bus.byte_value inside {fri_pkg::CHAR_GT, fri_pkg::CHAR_AT}) begin
         push_item.op = fri_pkg::OP_HEAD_BYTE;
      end else if (req_bus.byte_value inside
                   {fri_pkg::CHAR_SEMI, fri_pkg::CHAR_PLUS, fri_pkg::CHAR_SPACE}) begin
         push_item.op = fri_pkg::OP_SKIP_BYTE;
      end
   end

endmodule

/* sv/fri_queue.sv */
// ----------------------------------------------------------------------------
// FASTA record indexer queue
// Short FIFO of classified operations between the front and back end.
// ----------------------------------------------------------------------------
module fri_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  fri_pkg::item_type push_item,
   output logic              push_ready,
   output logic              pop_valid,
   output fri_pkg::item_type pop_item,
   input  logic              pop_ready
);

   fri_pkg::item_type                     entry_ff [fri_pkg::QUEUE_DEPTH];
   logic [fri_pkg::QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [fri_pkg::QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [fri_pkg::QUEUE_CNT_WIDTH-1:0]   count_ff, count_in;
   logic                                  push_fire;
   logic                                  pop_fire;

   assign push_ready = (count_ff != fri_pkg::QUEUE_CNT_WIDTH'(fri_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Pointer and fill count update; pointers wrap around the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == fri_pkg::QUEUE_PTR_WIDTH'(fri_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == fri_pkg::QUEUE_PTR_WIDTH'(fri_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* sv/fri_back.sv */
// ----------------------------------------------------------------------------
// FASTA record indexer back end
// Tracks line and record state, builds index records and holds the output
// register of the result channel.
// ----------------------------------------------------------------------------
module fri_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  fri_pkg::item_type pop_item,
   output logic              pop_ready,
   fri_rsp_if.source         rsp_bus
);

   fri_pkg::count_type line_start_ff, line_start_in;
   fri_pkg::count_type line_length_ff, line_length_in;
   logic               in_line_ff, in_line_in;
   fri_pkg::kind_type  line_kind_ff, line_kind_in;
   logic               header_seen_ff, header_seen_in;
   fri_pkg::count_type head_off_ff, head_off_in;
   fri_pkg::count_type seq_off_ff, seq_off_in;
   fri_pkg::count_type seq_len_ff, seq_len_in;
   fri_pkg::count_type widest_ff, widest_in;
   fri_pkg::count_type records_ff, records_in;

   logic               out_valid_ff, out_valid_in;
   logic [31:0]        out_number_ff, out_number_in;
   logic [31:0]        out_head_ff, out_head_in;
   logic [31:0]        out_seq_off_ff, out_seq_off_in;
   logic [31:0]        out_seq_len_ff, out_seq_len_in;
   logic [31:0]        out_widest_ff, out_widest_in;
   logic               out_final_ff, out_final_in;

   fri_pkg::count_type len_eff;
   fri_pkg::kind_type  kind_eff;
   fri_pkg::count_type next_start;
   fri_pkg::count_type fl_seq_off;
   fri_pkg::count_type fl_seq_len;
   fri_pkg::count_type fl_widest;
   fri_pkg::count_type end_seq_off;
   fri_pkg::count_type end_seq_len;
   fri_pkg::count_type end_widest;
   logic               pop_fire;
   logic               emit;

   // The back end advances whenever the output register is free or draining.
   assign pop_ready = !out_valid_ff || rsp_bus.ready;
   assign pop_fire  = pop_valid && pop_ready;

   // Record values as they stand once the current line is finished.
   always_comb begin
      len_eff    = in_line_ff ? line_length_ff : '0;
      kind_eff   = in_line_ff ? line_kind_ff : fri_pkg::KIND_SKIP;
      next_start = line_start_ff + len_eff + fri_pkg::COUNT_WIDTH'(1);
      fl_seq_off = seq_off_ff;
      fl_seq_len = seq_len_ff;
      fl_widest  = widest_ff;
      case (kind_eff)
         fri_pkg::KIND_HEAD: begin
            fl_seq_off = next_start;
         end
         fri_pkg::KIND_SKIP: begin
            if (seq_len_ff == '0) begin
               fl_seq_off = next_start;
            end
         end
         default: begin
            fl_seq_len = seq_len_ff + len_eff;
            if (len_eff > widest_ff) begin
               fl_widest = len_eff;
            end
         end
      endcase
      // At the end marker a line is finished only when one is open.
      end_seq_off = in_line_ff ? fl_seq_off : seq_off_ff;
      end_seq_len = in_line_ff ? fl_seq_len : seq_len_ff;
      end_widest  = in_line_ff ? fl_widest : widest_ff;
   end

   // State update for the operation at the queue head.
   always_comb begin
      line_start_in  = line_start_ff;
      line_length_in = line_length_ff;
      in_line_in     = in_line_ff;
      line_kind_in   = line_kind_ff;
      header_seen_in = header_seen_ff;
      head_off_in    = head_off_ff;
      seq_off_in     = seq_off_ff;
      seq_len_in     = seq_len_ff;
      widest_in      = widest_ff;
      records_in     = records_ff;
      emit           = 1'b0;
      out_number_in  = out_number_ff;
      out_head_in    = out_head_ff;
      out_seq_off_in = out_seq_off_ff;
      out_seq_len_in = out_seq_len_ff;
      out_widest_in  = out_widest_ff;
      out_final_in   = out_final_ff;

      if (pop_fire) begin
         case (pop_item.op)
            fri_pkg::OP_NEWLINE: begin
               line_start_in  = next_start;
               line_length_in = '0;
               in_line_in     = 1'b0;
               line_kind_in   = fri_pkg::KIND_SEQ;
               seq_off_in     = fl_seq_off;
               seq_len_in     = fl_seq_len;
               widest_in      = fl_widest;
            end
            fri_pkg::OP_END: begin
               if (end_seq_off != '0) begin
                  emit           = 1'b1;
                  out_number_in  = 32'(records_ff);
                  out_head_in    = 32'(head_off_ff);
                  out_seq_off_in = 32'(end_seq_off);
                  out_seq_len_in = 32'(end_seq_len);
                  out_widest_in  = 32'(end_widest);
                  out_final_in   = 1'b1;
               end
               // All line and record state returns to its reset value for the next file.
               line_start_in  = '0;
               line_length_in = '0;
               in_line_in     = 1'b0;
               line_kind_in   = fri_pkg::KIND_SEQ;
               header_seen_in = 1'b0;
               head_off_in    = '0;
               seq_off_in     = '0;
               seq_len_in     = '0;
               widest_in      = '0;
               records_in     = '0;
            end
            default: begin
               // An ordinary byte; the first one of a line sets its class.
               if (!in_line_ff) begin
                  in_line_in = 1'b1;
                  if (pop_item.op == fri_pkg::OP_HEAD_BYTE) begin
                     line_kind_in = fri_pkg::KIND_HEAD;
                     if (header_seen_ff) begin
                        emit           = 1'b1;
                        out_number_in  = 32'(records_ff);
                        out_head_in    = 32'(head_off_ff);
                        out_seq_off_in = 32'(seq_off_ff);
                        out_seq_len_in = 32'(seq_len_ff);
                        out_widest_in  = 32'(widest_ff);
                        out_final_in   = 1'b0;
                        records_in     = records_ff + fri_pkg::COUNT_WIDTH'(1);
                     end
                     header_seen_in = 1'b1;
                     head_off_in    = line_start_ff;
                     seq_off_in     = '0;
                     seq_len_in     = '0;
                     widest_in      = '0;
                  end else if (pop_item.op == fri_pkg::OP_SKIP_BYTE) begin
                     line_kind_in = fri_pkg::KIND_SKIP;
                  end else begin
                     line_kind_in = fri_pkg::KIND_SEQ;
                  end
               end
               line_length_in = line_length_ff + fri_pkg::COUNT_WIDTH'(1);
            end
         endcase
      end

      // The output register fills on a new record and empties on a taken beat.
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control and record state.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_start_ff  <= '0;
         line_length_ff <= '0;
         in_line_ff     <= 1'b0;
         line_kind_ff   <= fri_pkg::KIND_SEQ;
         header_seen_ff <= 1'b0;
         head_off_ff    <= '0;
         seq_off_ff     <= '0;
         seq_len_ff     <= '0;
         widest_ff      <= '0;
         records_ff     <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         line_start_ff  <= line_start_in;
         line_length_ff <= line_length_in;
         in_line_ff     <= in_line_in;
         line_kind_ff   <= line_kind_in;
         header_seen_ff <= header_seen_in;
         head_off_ff    <= head_off_in;
         seq_off_ff     <= seq_off_in;
         seq_len_ff     <= seq_len_in;
         widest_ff      <= widest_in;
         records_ff     <= records_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      out_number_ff  <= out_number_in;
      out_head_ff    <= out_head_in;
      out_seq_off_ff <= out_seq_off_in;
      out_seq_len_ff <= out_seq_len_in;
      out_widest_ff  <= out_widest_in;
      out_final_ff   <= out_final_in;
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.record_number   = out_number_ff;
   assign rsp_bus.header_start    = out_head_ff;
   assign rsp_bus.sequence_offset = out_seq_off_ff;
   assign rsp_bus.sequence_length = out_seq_len_ff;
   assign rsp_bus.widest_line     = out_widest_ff;
   assign rsp_bus.final_record    = out_final_ff;

endmodule

/* dv/fri_index_check_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FASTA record indexer scoreboard
// Predicts the index records of a FASTA/FASTQ byte stream beat by beat and
// checks every record that leaves the block against the oldest prediction.
// ----------------------------------------------------------------------------
package fri_index_check_pkg;

   // One index record as it appears on the result channel.
   typedef struct packed {
      logic [fri_pkg::OUT_WIDTH-1:0] record_number;
      logic [fri_pkg::OUT_WIDTH-1:0] header_start;
      logic [fri_pkg::OUT_WIDTH-1:0] sequence_offset;
      logic [fri_pkg::OUT_WIDTH-1:0] sequence_length;
      logic [fri_pkg::OUT_WIDTH-1:0] widest_line;
      logic                          final_record;
   } index_record_type;

   class index_checker_type;
      // Scanner state for the line being read.
      fri_pkg::count_type line_origin;
      fri_pkg::count_type line_bytes;
      bit                 line_open;
      fri_pkg::kind_type  line_class;
      // Record under construction.
      bit                 header_found;
      fri_pkg::count_type rec_header;
      fri_pkg::count_type rec_seq_start;
      fri_pkg::count_type rec_seq_total;
      fri_pkg::count_type rec_widest;
      fri_pkg::count_type emitted;

      index_record_type expected_records[$];
      int unsigned      fault_count;

      function new();
         fault_count = 0;
         clear();
      endfunction

      // Return to the state of a fresh file.
      function void clear();
         line_origin   = '0;
         line_bytes    = '0;
         line_open     = 1'b0;
         line_class    = fri_pkg::KIND_SEQ;
         header_found  = 1'b0;
         rec_header    = '0;
         rec_seq_start = '0;
         rec_seq_total = '0;
         rec_widest    = '0;
         emitted       = '0;
      endfunction

      function int pending();
         return expected_records.size();
      endfunction

      function string show(index_record_type r);
         return $sformatf("#%0d hdr=%0d seq=%0d len=%0d wide=%0d fin=%0b",
                          r.record_number, r.header_start, r.sequence_offset,
                          r.sequence_length, r.widest_line, r.final_record);
      endfunction

      // Count a failure; only the first ten are described.
      function void flag(string msg);
         fault_count++;
         if (fault_count <= 10) begin
            $display("%s", msg);
         end
      endfunction

      // Queue the record built so far and advance the record count.
      function void push_record(bit is_final);
         index_record_type r;
         r.record_number   = emitted;
         r.header_start    = rec_header;
         r.sequence_offset = rec_seq_start;
         r.sequence_length = rec_seq_total;
         r.widest_line     = rec_widest;
         r.final_record    = is_final;
         expected_records.insert(expected_records.size(), r);
         emitted++;
      endfunction

      // Close the current line as a newline would.
      function void close_line();
         fri_pkg::count_type len;
         fri_pkg::kind_type  kind;
         fri_pkg::count_type next_start;
         if (line_open) begin
            len  = line_bytes;
            kind = line_class;
         end else begin
            len  = '0;
            kind = fri_pkg::KIND_SKIP;
         end
         next_start = line_origin + len + 1'b1;
         case (kind)
            fri_pkg::KIND_HEAD: begin
               rec_seq_start = next_start;
            end
            fri_pkg::KIND_SKIP: begin
               if (rec_seq_total == 0) rec_seq_start = next_start;
            end
            default: begin
               rec_seq_total = rec_seq_total + len;
               if (len > rec_widest) rec_widest = len;
            end
         endcase
         line_origin = next_start;
         line_bytes  = '0;
         line_open   = 1'b0;
         line_class  = fri_pkg::KIND_SEQ;
      endfunction

      // Update the prediction with one accepted input beat.
      function void take_beat(logic action, logic [7:0] value);
         if (action == fri_pkg::ACTION_END) begin
            if (line_open) close_line();
            if (rec_seq_start != 0) push_record(1'b1);
            clear();
            return;
         end
         if (value == fri_pkg::CHAR_NEWLINE) begin
            close_line();
            return;
         end
         // The first byte of a line decides its class.
         if (!line_open) begin
            line_open = 1'b1;
            if (value == fri_pkg::CHAR_GT || value == fri_pkg::CHAR_AT) begin
               line_class = fri_pkg::KIND_HEAD;
               if (header_found) push_record(1'b0);
               header_found  = 1'b1;
               rec_header    = line_origin;
               rec_seq_start = '0;
               rec_seq_total = '0;
               rec_widest    = '0;
            end else if (value == fri_pkg::CHAR_SEMI || value == fri_pkg::CHAR_PLUS ||
                         value == fri_pkg::CHAR_SPACE) begin
               line_class = fri_pkg::KIND_SKIP;
            end else begin
               line_class = fri_pkg::KIND_SEQ;
            end
         end
         line_bytes++;
      endfunction

      // Compare one record from the block with the oldest prediction.
      function void check_record(index_record_type got);
         index_record_type want;
         string            bad;
         if (expected_records.size() == 0) begin
            flag({"unexpected record: ", show(got)});
            return;
         end
         want = expected_records.pop_front();
         bad  = "";
         if (got.record_number !== want.record_number) bad = {bad, " record_number"};
         if (got.header_start !== want.header_start) bad = {bad, " header_start"};
         if (got.sequence_offset !== want.sequence_offset) bad = {bad, " sequence_offset"};
         if (got.sequence_length !== want.sequence_length) bad = {bad, " sequence_length"};
         if (got.widest_line !== want.widest_line) bad = {bad, " widest_line"};
         if (got.final_record !== want.final_record) bad = {bad, " final_record"};
         if (bad != "") begin
            flag({"record mismatch in", bad, ": expected ", show(want), ", got ", show(got)});
         end
      endfunction

      // Predictions still waiting at the end are failures.
      function void finish_check();
         while (expected_records.size() != 0) begin
            flag({"missing record: ", show(expected_records.pop_front())});
         end
      endfunction
   endclass

endpackage

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FASTA record indexer testbench
// Streams directed and random FASTA/FASTQ files, with end markers, into the
// indexer under random idling on both channels and one long result stall,
// and checks every index record against a beat-level prediction.
// ----------------------------------------------------------------------------
module tb;

   localparam int RANDOM_BEATS    = 1400;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PRESSURE_CYCLES = 200;
   localparam int PRESSURE_AFTER  = 10;

   logic clock;
   logic reset;

   fri_req_if req_bus ();
   fri_rsp_if rsp_bus ();

   fasta_record_indexer i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   fri_index_check_pkg::index_checker_type board;
   int unsigned  beats_sent;
   int unsigned  records_seen;
   int unsigned  idle_cycles;
   bit           sender_calm;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   // A nucleotide code, rarely any byte other than newline.
   function automatic logic [7:0] pick_base();
      string       codes;
      logic [7:0]  b;
      codes = "ACGTNacgtn";
      if ($urandom_range(0, 49) == 0) begin
         b = 8'($urandom_range(0, 255));
         if (b == fri_pkg::CHAR_NEWLINE) b = 8'h0D;
         return b;
      end
      return codes[$urandom_range(0, 9)];
   endfunction

   // Offer one beat and hold it until the block takes it.
   task automatic send_beat(input logic action, input logic [7:0] value);
      int gap;
      gap = sender_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= action;
      req_bus.byte_value <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_beat(fri_pkg::ACTION_BYTE, s[i]);
      end
   endtask

   task automatic send_bases(input int count);
      repeat (count) send_beat(fri_pkg::ACTION_BYTE, pick_base());
   endtask

   // Printable text, as in titles and quality strings.
   task automatic send_title(input int count);
      repeat (count) send_beat(fri_pkg::ACTION_BYTE, 8'($urandom_range(32, 126)));
   endtask

   // A well-formed FASTA or FASTQ file with random content, closed by an end marker.
   task automatic send_file();
      int  records;
      int  lines;
      int  len;
      bit  fastq;
      fastq       = ($urandom_range(0, 3) == 0);
      sender_calm = ($urandom_range(0, 4) == 0);
      // Sometimes a comment and stray sequence come before the first header.
      if ($urandom_range(0, 9) == 0) begin
         send_beat(fri_pkg::ACTION_BYTE, fri_pkg::CHAR_SEMI);
         send_title(3);
         send_beat(fri_pkg::ACTION_BYTE, fri_pkg::CHAR_NEWLINE);
         send_bases($urandom_range(0, 5));
         send_beat(fri_pkg::ACTION_BYTE, fri_pkg::CHAR_NEWLINE);
      end
      records = $urandom_range(1, 5);
      repeat (records) begin
         if (fastq || $urandom_range(0, 7) == 0) begin
            send_beat(fri_pkg::ACTION_BYTE, fri_pkg::CHAR_AT);
         end else begin
            send_beat(fri_pkg::ACTION_BYTE, fri_pkg::CHAR_GT);
         end
         send_title($urandom_range(0, 10));
         send_beat(fri_pkg::ACTION_BYTE, fri_pkg::CHAR_NEWLINE);
         if (fastq) begin
            len = $urandom_range(1, 30);
            send_bases(len);
            send_beat(fri_pkg::ACTION_BYTE, fri_pkg::CHAR_NEWLINE);
            send_beat(fri_pkg::ACTION_BYTE, fri_pkg::CHAR_PLUS);
            if ($urandom_range(0, 1) == 0) send_title($urandom_range(1, 4));
            send_beat(fri_pkg::ACTION_BYTE, fri_pkg::CHAR_NEWLINE);
            send_title(len);
            send_beat(fri_pkg::ACTION_BYTE, fri_pkg::CHAR_NEWLINE);
         end else begin
            lines = $urandom_range(0, 4);
            repeat (lines) begin
               case ($urandom_range(0, 9))
                  0: begin
                     send_beat(fri_pkg::ACTION_BYTE, fri_pkg::CHAR_SEMI);
                     send_title(2);
                  end
                  1: begin
                     send_beat(fri_pkg::ACTION_BYTE, fri_pkg::CHAR_SPACE);
                     send_bases(3);
                  end
                  2: begin
                     // Empty line.
                  end
                  default: begin
                     if ($urandom_range(0, 9) == 0) len = $urandom_range(60, 200);
                     else len = $urandom_range(1, 24);
                     send_bases(len);
                  end
               endcase
               send_beat(fri_pkg::ACTION_BYTE, fri_pkg::CHAR_NEWLINE);
            end
         end
      end
      // An unterminated last line now and then.
      if ($urandom_range(0, 3) == 0) send_bases($urandom_range(1, 8));
      send_beat(fri_pkg::ACTION_END, 8'($urandom_range(0, 255)));
   endtask

   // Random bytes rich in newlines and class characters, not always closed.
   task automatic send_noise();
      int   count;
      int   r;
      logic [7:0] b;
      sender_calm = 1'b0;
      count = $urandom_range(4, 40);
      repeat (count) begin
         r = $urandom_range(0, 9);
         if (r < 3) begin
            b = fri_pkg::CHAR_NEWLINE;
         end else if (r < 5) begin
            case ($urandom_range(0, 4))
               0: b = fri_pkg::CHAR_GT;
               1: b = fri_pkg::CHAR_AT;
               2: b = fri_pkg::CHAR_SEMI;
               3: b = fri_pkg::CHAR_PLUS;
               default: b = fri_pkg::CHAR_SPACE;
            endcase
         end else begin
            b = 8'($urandom_range(0, 255));
         end
         send_beat(fri_pkg::ACTION_BYTE, b);
      end
      if ($urandom_range(0, 1) == 0) begin
         send_beat(fri_pkg::ACTION_END, 8'($urandom_range(0, 255)));
      end
   endtask

   // Beat monitor: feeds the prediction and checks records as they are taken.
   always @(posedge clock) begin : beat_monitor
      fri_index_check_pkg::index_record_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            board.take_beat(req_bus.action, req_bus.byte_value);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.record_number   = rsp_bus.record_number;
            got.header_start    = rsp_bus.header_start;
            got.sequence_offset = rsp_bus.sequence_offset;
            got.sequence_length = rsp_bus.sequence_length;
            got.widest_line     = rsp_bus.widest_line;
            got.final_record    = rsp_bus.final_record;
            board.check_record(got);
            records_seen++;
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
   end

   // Result receiver: random stalls, calm stretches and one long hold-off.
   initial begin
      int  hold;
      int  stretch;
      bit  calm;
      bit  pressure_done;
      stretch       = 0;
      calm          = 1'b0;
      pressure_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!pressure_done && records_seen >= PRESSURE_AFTER) begin
            pressure_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
         end
         if (stretch == 0) begin
            calm    = ($urandom_range(0, 3) == 0);
            stretch = $urandom_range(20, 200);
         end
         stretch--;
         hold = calm ? 0 : pick_gap();
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Watchdog on cycles in which neither channel moves a beat.
   initial begin
      idle_cycles = 0;
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("tb: errors");
      $finish;
   end

   // Main sequence: reset, directed files, random files, drain.
   initial begin
      board        = new();
      beats_sent   = 0;
      records_seen = 0;
      sender_calm  = 1'b0;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.action     <= fri_pkg::ACTION_BYTE;
      req_bus.byte_value <= 8'h00;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // An empty file yields nothing.
      send_beat(fri_pkg::ACTION_END, 8'h00);
      // Comment and space lines with no header, then an unterminated sequence line.
      send_text(";\n x\nA");
      send_beat(fri_pkg::ACTION_END, 8'hFF);
      // Header, empty line, sequence, plus line, FASTQ-style header with an empty
      // title, then a line with 0xFF, zero and carriage return bytes; the end
      // marker follows a newline.
      send_text(">h\n\nAC\n+\n@\nGT");
      send_beat(fri_pkg::ACTION_BYTE, 8'hFF);
      send_beat(fri_pkg::ACTION_BYTE, 8'h00);
      send_text("\r\n");
      send_beat(fri_pkg::ACTION_END, 8'h5A);

      while (beats_sent < RANDOM_BEATS) begin
         if ($urandom_range(0, 9) < 8) send_file();
         else send_noise();
      end
      req_bus.valid <= 1'b0;

      // Let the monitor note the last beat before waiting on the predictions.
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      board.finish_check();
      if (board.fault_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
